>>> rtl/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared types and codes for the file delivery sender controller.
// ----------------------------------------------------------------------------
package fdsc_pkg;

    // most actions one event can produce
    localparam int MAX_ACTIONS = 5;
    localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        PH_META = 2'd0,
        PH_FILE = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_ENTER       = 4'd0,
        EV_SEND_DATA   = 4'd1,
        EV_ABANDON     = 4'd2,
        EV_CANCEL_NOTE = 4'd3,
        EV_SUSP_NOTE   = 4'd4,
        EV_PUT         = 4'd5,
        EV_SUSP_REQ    = 4'd6,
        EV_RESUME      = 4'd7,
        EV_CANCEL_REQ  = 4'd8,
        EV_REPORT      = 4'd9,
        EV_FREEZE      = 4'd10,
        EV_THAW        = 4'd11
    } event_t;

    typedef enum logic [3:0] {
        ACT_TXN     = 4'd0,
        ACT_META    = 4'd1,
        ACT_DATA    = 4'd2,
        ACT_EOF     = 4'd3,
        ACT_EOFSENT = 4'd4,
        ACT_FIN     = 4'd5,
        ACT_ABAND   = 4'd6,
        ACT_SUSP    = 4'd7,
        ACT_RESUME  = 4'd8,
        ACT_REPORT  = 4'd9,
        ACT_REQ     = 4'd10,
        ACT_ERR     = 4'd11
    } action_t;

    // run of actions decided for one event
    typedef struct packed {
        action_t [MAX_ACTIONS-1:0] acts;
        cnt_t                      n;
        event_t                    req;
        logic                      eof_cond;
    } plan_t;

endpackage

>>> rtl/fdsc_front.sv
// ----------------------------------------------------------------------------
// fdsc_front
// Takes events, keeps the transaction state, builds the run of actions.
// ----------------------------------------------------------------------------
module fdsc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [3:0]       cmd,
    input  logic             transport_ready,
    input  logic             file_data_present,
    input  logic             file_fully_sent,
    input  logic             metadata_send_ok,
    input  logic             data_send_ok,
    input  logic             eof_send_ok,
    output logic             push,
    output fdsc_pkg::plan_t  plan
);

    fdsc_pkg::phase_t phase_reg, phase_next;
    logic susp_reg, susp_next;
    logic frozen_reg, frozen_next;
    logic cancel_reg, cancel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fdsc_pkg::PH_META;
            susp_reg   <= 1'b0;
            frozen_reg <= 1'b0;
            cancel_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            susp_reg   <= susp_next;
            frozen_reg <= frozen_next;
            cancel_reg <= cancel_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        susp_next     = susp_reg;
        frozen_next   = frozen_reg;
        cancel_next   = cancel_reg;
        plan.acts     = '{default: fdsc_pkg::ACT_TXN};
        plan.n        = '0;
        plan.req      = fdsc_pkg::EV_ENTER;
        plan.eof_cond = cancel_reg;

        case (phase_reg)
            fdsc_pkg::PH_META:
            begin
                if (cmd == fdsc_pkg::EV_ENTER)
                begin
                    susp_next   = 1'b0;
                    frozen_next = 1'b0;
                    cancel_next = 1'b0;
                end
                else if (cmd == fdsc_pkg::EV_PUT)
                begin
                    plan.acts[0] = fdsc_pkg::ACT_TXN;
                    plan.acts[1] = fdsc_pkg::ACT_META;
                    if (!metadata_send_ok)
                    begin
                        plan.n     = fdsc_pkg::CNT_W'(2);
                        phase_next = fdsc_pkg::PH_DONE;
                    end
                    else if (file_data_present)
                    begin
                        plan.acts[2] = fdsc_pkg::ACT_REQ;
                        plan.req     = fdsc_pkg::EV_ENTER;
                        plan.n       = fdsc_pkg::CNT_W'(3);
                        phase_next   = fdsc_pkg::PH_FILE;
                    end
                    else
                    begin
                        plan.acts[2] = fdsc_pkg::ACT_EOF;
                        plan.acts[3] = fdsc_pkg::ACT_EOFSENT;
                        plan.acts[4] = fdsc_pkg::ACT_FIN;
                        plan.n       = eof_send_ok ? fdsc_pkg::CNT_W'(5)
                                                   : fdsc_pkg::CNT_W'(3);
                        phase_next   = fdsc_pkg::PH_DONE;
                    end
                end
                else
                begin
                    plan.acts[0] = fdsc_pkg::ACT_ERR;
                    plan.n       = fdsc_pkg::CNT_W'(1);
                end
            end

            fdsc_pkg::PH_FILE:
            begin
                case (cmd)
                    fdsc_pkg::EV_ENTER:
                    begin
                        plan.acts[0] = fdsc_pkg::ACT_REQ;
                        plan.req     = fdsc_pkg::EV_SEND_DATA;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                    end
                    fdsc_pkg::EV_SEND_DATA:
                    begin
                        // held back while suspended, frozen or transport busy
                        if (!susp_reg && !frozen_reg && transport_ready)
                        begin
                            if (file_fully_sent)
                            begin
                                plan.acts[0] = fdsc_pkg::ACT_EOF;
                                plan.acts[1] = fdsc_pkg::ACT_EOFSENT;
                                plan.acts[2] = fdsc_pkg::ACT_FIN;
                                plan.n       = eof_send_ok ? fdsc_pkg::CNT_W'(3)
                                                           : fdsc_pkg::CNT_W'(1);
                                phase_next   = fdsc_pkg::PH_DONE;
                            end
                            else
                            begin
                                plan.acts[0] = fdsc_pkg::ACT_DATA;
                                plan.acts[1] = fdsc_pkg::ACT_REQ;
                                plan.req     = fdsc_pkg::EV_SEND_DATA;
                                if (data_send_ok)
                                begin
                                    plan.n = fdsc_pkg::CNT_W'(2);
                                end
                                else
                                begin
                                    plan.n     = fdsc_pkg::CNT_W'(1);
                                    phase_next = fdsc_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                    fdsc_pkg::EV_ABANDON:
                    begin
                        plan.acts[0] = fdsc_pkg::ACT_ABAND;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                        phase_next   = fdsc_pkg::PH_DONE;
                    end
                    fdsc_pkg::EV_CANCEL_NOTE:
                    begin
                        // goes on whether or not the eof send succeeds
                        plan.acts[0] = fdsc_pkg::ACT_EOF;
                        plan.acts[1] = fdsc_pkg::ACT_FIN;
                        plan.n       = fdsc_pkg::CNT_W'(2);
                        phase_next   = fdsc_pkg::PH_DONE;
                    end
                    fdsc_pkg::EV_SUSP_NOTE:
                    begin
                        if (!susp_reg)
                        begin
                            plan.acts[0] = fdsc_pkg::ACT_SUSP;
                            plan.n       = fdsc_pkg::CNT_W'(1);
                            susp_next    = 1'b1;
                        end
                    end
                    fdsc_pkg::EV_SUSP_REQ:
                    begin
                        plan.acts[0] = fdsc_pkg::ACT_REQ;
                        plan.req     = fdsc_pkg::EV_SUSP_NOTE;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                    end
                    fdsc_pkg::EV_RESUME:
                    begin
                        plan.req = fdsc_pkg::EV_SEND_DATA;
                        if (susp_reg)
                        begin
                            plan.acts[0] = fdsc_pkg::ACT_RESUME;
                            plan.acts[1] = fdsc_pkg::ACT_REQ;
                            plan.n       = fdsc_pkg::CNT_W'(2);
                            susp_next    = 1'b0;
                        end
                        else
                        begin
                            plan.acts[0] = fdsc_pkg::ACT_REQ;
                            plan.n       = fdsc_pkg::CNT_W'(1);
                        end
                    end
                    fdsc_pkg::EV_CANCEL_REQ:
                    begin
                        cancel_next  = 1'b1;
                        plan.acts[0] = fdsc_pkg::ACT_REQ;
                        plan.req     = fdsc_pkg::EV_CANCEL_NOTE;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                    end
                    fdsc_pkg::EV_REPORT:
                    begin
                        plan.acts[0] = fdsc_pkg::ACT_REPORT;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                    end
                    fdsc_pkg::EV_FREEZE:
                    begin
                        frozen_next = 1'b1;
                    end
                    fdsc_pkg::EV_THAW:
                    begin
                        if (frozen_reg)
                        begin
                            frozen_next  = 1'b0;
                            plan.acts[0] = fdsc_pkg::ACT_REQ;
                            plan.req     = fdsc_pkg::EV_SEND_DATA;
                            plan.n       = fdsc_pkg::CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        plan.acts[0] = fdsc_pkg::ACT_ERR;
                        plan.n       = fdsc_pkg::CNT_W'(1);
                    end
                endcase
            end

            default:
            begin
                // completed (and the unused code): every event ignored
            end
        endcase
    end

    // events with no action never reach the queue
    assign push = accept && (plan.n != '0);

`ifndef SYNTH
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == fdsc_pkg::PH_DONE) |-> !push)
        else $error("event in completed phase produced actions");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fdsc_pkg::PH_DONE) |=> (phase_reg == fdsc_pkg::PH_DONE))
        else $error("left completed phase");

    a_flags_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == fdsc_pkg::PH_META && cmd == fdsc_pkg::EV_ENTER)
        |=> (!susp_reg && !frozen_reg && !cancel_reg))
        else $error("enter did not clear flags");
`endif

endmodule

>>> rtl/fdsc_queue.sv
// ----------------------------------------------------------------------------
// fdsc_queue
// Small FIFO of action plans between front and back.
// ----------------------------------------------------------------------------
module fdsc_queue #(
    parameter int Depth = fdsc_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fdsc_pkg::plan_t push_plan,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output fdsc_pkg::plan_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    fdsc_pkg::plan_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_plan;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/fdsc_back.sv
// ----------------------------------------------------------------------------
// fdsc_back
// Plays out one action per cycle into the output register while out_ready lets it.
// ----------------------------------------------------------------------------
module fdsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  fdsc_pkg::plan_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [3:0]      action,
    output logic [3:0]      requested_event,
    output logic            eof_condition,
    output logic            last
);

    fdsc_pkg::cnt_t idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    logic [3:0]     action_reg, action_next;
    logic [3:0]     req_reg, req_next;
    logic           cond_reg, cond_next;
    logic           last_reg, last_next;
    logic           load;
    fdsc_pkg::action_t cur_act;

    assign load    = q_valid && (!out_valid_reg || out_ready);
    assign cur_act = head.acts[idx_reg];

    always_comb
    begin
        last_next      = ((idx_reg + fdsc_pkg::CNT_W'(1)) == head.n);
        action_next    = cur_act;
        req_next       = (cur_act == fdsc_pkg::ACT_REQ) ? head.req : 4'd0;
        cond_next      = (cur_act == fdsc_pkg::ACT_EOF) ? head.eof_cond : 1'b0;
        pop            = load && last_next;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_next ? '0 : idx_reg + fdsc_pkg::CNT_W'(1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action_next;
            req_reg    <= req_next;
            cond_reg   <= cond_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign requested_event = req_reg;
    assign eof_condition   = cond_reg;
    assign last            = last_reg;

`ifndef SYNTH
    a_plan_len: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (head.n != '0 && head.n <= fdsc_pkg::CNT_W'(fdsc_pkg::MAX_ACTIONS)))
        else $error("queued plan has bad length");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg < head.n))
        else $error("action index past plan end");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == '0))
        else $error("index not rewound between plans");
`endif

endmodule

>>> rtl/file_delivery_sender_controller_unit.sv
// ----------------------------------------------------------------------------
// file_delivery_sender_controller_unit
// Controller of an unacknowledged file-delivery sender.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event code with its status
//   bits. Output channel (out_valid/out_ready) carries the actions that the
//   event causes, one per item, in order; last marks the final one.
//   An event that causes no action produces no output item.
// Output path: the front decodes an accepted event into the queue, and the
//   back then loads its actions from the queue into the output register,
//   from which the receiver takes them.
// Throughput: the output side moves one action per cycle while the receiver
//   is ready; an event has one to five actions. Events with no action put
//   nothing into the queue. The front keeps taking events while the queue
//   has room.
// Reset: phase back to metadata, flags and cancel condition cleared, queue
//   and output register emptied.
// Receiver stall: the output register holds its item; the back part stops,
//   the queue fills, then in_ready drops until room frees up.
// ----------------------------------------------------------------------------
module file_delivery_sender_controller_unit #(
    parameter int QueueDepth = fdsc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] cmd,
    input  logic       transport_ready,
    input  logic       file_data_present,
    input  logic       file_fully_sent,
    input  logic       metadata_send_ok,
    input  logic       data_send_ok,
    input  logic       eof_send_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] action,
    output logic [3:0] requested_event,
    output logic       eof_condition,
    output logic       last
);

    logic            accept;
    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;
    fdsc_pkg::plan_t push_plan;
    fdsc_pkg::plan_t head;

    // front accepts whenever the queue can take a plan
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // front: state keeping and classification of each event
    fdsc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .cmd               (cmd),
        .transport_ready   (transport_ready),
        .file_data_present (file_data_present),
        .file_fully_sent   (file_fully_sent),
        .metadata_send_ok  (metadata_send_ok),
        .data_send_ok      (data_send_ok),
        .eof_send_ok       (eof_send_ok),
        .push              (push),
        .plan              (push_plan)
    );

    // decouples front and back so each stalls on its own
    fdsc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (push_plan),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    // back: one action per cycle into the output register while the receiver takes them
    fdsc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .requested_event (requested_event),
        .eof_condition   (eof_condition),
        .last            (last)
    );

endmodule

>>> tb/fdsc_action_checker.sv
// ----------------------------------------------------------------------------
// fdsc_action_checker
// Scoreboard for the file delivery sender controller: watches the event and
// action channels, predicts each event's run of actions and checks them.
// ----------------------------------------------------------------------------
module fdsc_action_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [3:0] cmd,
    input  logic       transport_ready,
    input  logic       file_data_present,
    input  logic       file_fully_sent,
    input  logic       metadata_send_ok,
    input  logic       data_send_ok,
    input  logic       eof_send_ok,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] action,
    input  logic [3:0] requested_event,
    input  logic       eof_condition,
    input  logic       last,
    output int         fails,
    output int         backlog
);

    typedef struct packed {
        fdsc_pkg::action_t act;
        logic [3:0]        req;
        logic              eof_cond;
        logic              last;
    } action_rec_t;

    // shadow of the controller state
    fdsc_pkg::phase_t ph;
    bit               susp_q;
    bit               frz_q;
    bit               cancel_q;

    action_rec_t run_buf [fdsc_pkg::MAX_ACTIONS];
    int          run_len;
    action_rec_t due_actions [$];

    function void add_action(input fdsc_pkg::action_t a, input logic [3:0] ev);
        if (run_len < fdsc_pkg::MAX_ACTIONS) begin
            run_buf[run_len] = '{act:      a,
                                 req:      (a == fdsc_pkg::ACT_REQ) ? ev : '0,
                                 eof_cond: (a == fdsc_pkg::ACT_EOF) ? cancel_q : 1'b0,
                                 last:     1'b0};
            run_len++;
        end
    endfunction

    // eof send, then eof-sent and finished only when it went out
    function void close_with_eof(input logic eok);
        add_action(fdsc_pkg::ACT_EOF, '0);
        ph = fdsc_pkg::PH_DONE;
        if (eok) begin
            add_action(fdsc_pkg::ACT_EOFSENT, '0);
            add_action(fdsc_pkg::ACT_FIN, '0);
        end
    endfunction

    function void predict_actions(input logic [3:0] ev, input logic tr, input logic fdp,
                                  input logic ffs, input logic mok, input logic dok,
                                  input logic eok);
        action_rec_t rec;
        run_len = 0;
        case (ph)
            fdsc_pkg::PH_META: begin
                if (ev == fdsc_pkg::EV_ENTER) begin
                    susp_q   = 1'b0;
                    frz_q    = 1'b0;
                    cancel_q = 1'b0;
                end else if (ev == fdsc_pkg::EV_PUT) begin
                    add_action(fdsc_pkg::ACT_TXN, '0);
                    add_action(fdsc_pkg::ACT_META, '0);
                    if (!mok) begin
                        ph = fdsc_pkg::PH_DONE;
                    end else if (fdp) begin
                        ph = fdsc_pkg::PH_FILE;
                        add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_ENTER);
                    end else begin
                        close_with_eof(eok);
                    end
                end else begin
                    add_action(fdsc_pkg::ACT_ERR, '0);
                end
            end
            fdsc_pkg::PH_FILE: begin
                case (ev)
                    fdsc_pkg::EV_ENTER:
                        add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_SEND_DATA);
                    fdsc_pkg::EV_SEND_DATA: begin
                        if (!susp_q && !frz_q && tr) begin
                            if (ffs) begin
                                close_with_eof(eok);
                            end else begin
                                add_action(fdsc_pkg::ACT_DATA, '0);
                                if (!dok)
                                    ph = fdsc_pkg::PH_DONE;
                                else
                                    add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_SEND_DATA);
                            end
                        end
                    end
                    fdsc_pkg::EV_ABANDON: begin
                        add_action(fdsc_pkg::ACT_ABAND, '0);
                        ph = fdsc_pkg::PH_DONE;
                    end
                    // cancel notice finishes whatever the eof send did
                    fdsc_pkg::EV_CANCEL_NOTE: begin
                        add_action(fdsc_pkg::ACT_EOF, '0);
                        add_action(fdsc_pkg::ACT_FIN, '0);
                        ph = fdsc_pkg::PH_DONE;
                    end
                    fdsc_pkg::EV_SUSP_NOTE: begin
                        if (!susp_q) begin
                            add_action(fdsc_pkg::ACT_SUSP, '0);
                            susp_q = 1'b1;
                        end
                    end
                    fdsc_pkg::EV_SUSP_REQ:
                        add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_SUSP_NOTE);
                    fdsc_pkg::EV_RESUME: begin
                        if (susp_q) begin
                            add_action(fdsc_pkg::ACT_RESUME, '0);
                            susp_q = 1'b0;
                        end
                        add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_SEND_DATA);
                    end
                    fdsc_pkg::EV_CANCEL_REQ: begin
                        cancel_q = 1'b1;
                        add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_CANCEL_NOTE);
                    end
                    fdsc_pkg::EV_REPORT:
                        add_action(fdsc_pkg::ACT_REPORT, '0);
                    fdsc_pkg::EV_FREEZE:
                        frz_q = 1'b1;
                    fdsc_pkg::EV_THAW: begin
                        if (frz_q) begin
                            frz_q = 1'b0;
                            add_action(fdsc_pkg::ACT_REQ, fdsc_pkg::EV_SEND_DATA);
                        end
                    end
                    default:
                        add_action(fdsc_pkg::ACT_ERR, '0);
                endcase
            end
            default: ; // completed, or the unused phase code
        endcase
        for (int i = 0; i < run_len; i++) begin
            rec      = run_buf[i];
            rec.last = (i == run_len - 1);
            due_actions.push_back(rec);
        end
    endfunction

    function void check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        action_rec_t want;
        if (!rst_n) begin
            ph       = fdsc_pkg::PH_META;
            susp_q   = 1'b0;
            frz_q    = 1'b0;
            cancel_q = 1'b0;
            due_actions.delete();
            fails    = 0;
            backlog  = 0;
        end else begin
            if (in_valid && in_ready)
                predict_actions(cmd, transport_ready, file_data_present, file_fully_sent,
                                metadata_send_ok, data_send_ok, eof_send_ok);
            if (out_valid && out_ready) begin
                if (due_actions.size() == 0) begin
                    $error("action: expected none, got %0d", action);
                    fails++;
                end else begin
                    want = due_actions.pop_front();
                    check_field("action", want.act, action);
                    check_field("requested_event", want.req, requested_event);
                    check_field("eof_condition", 4'(want.eof_cond), 4'(eof_condition));
                    check_field("last", 4'(want.last), 4'(last));
                end
            end
            backlog = due_actions.size();
        end
    end

endmodule

>>> tb/tb_file_delivery_sender_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_file_delivery_sender_controller_unit
// Drives events into the sender controller and gives the verdict. A short
// directed run walks the metadata phase and every file-phase event but abandon
// and cancel note; a long random run stays in the file phase, and one closing
// event ends it before a few ignored events. Checking is in fdsc_action_checker.
// ----------------------------------------------------------------------------
module tb_file_delivery_sender_controller_unit;

    // event codes with no meaning in any phase
    localparam logic [3:0] EV_RSVD_LO = 4'd12;
    localparam logic [3:0] EV_RSVD_HI = 4'd15;

    localparam int IDLE_PCT     = 12;       // idle cycles per hundred, each side
    localparam int RANDOM_ITEMS = 430;
    localparam int CALM_FIRST   = 150;      // first random item sent with no idling
    localparam int CALM_LAST    = 260;
    localparam int TAIL_ITEMS   = 10;       // events after the transaction ended
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT      = 2_000_000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] cmd;
    logic       transport_ready;
    logic       file_data_present;
    logic       file_fully_sent;
    logic       metadata_send_ok;
    logic       data_send_ok;
    logic       eof_send_ok;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] action;
    logic [3:0] requested_event;
    logic       eof_condition;
    logic       last;

    int fails;
    int backlog;
    bit calm;       // both sides run without idling
    bit cancel_ok;  // whether this run may raise the cancel condition

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    file_delivery_sender_controller_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .transport_ready   (transport_ready),
        .file_data_present (file_data_present),
        .file_fully_sent   (file_fully_sent),
        .metadata_send_ok  (metadata_send_ok),
        .data_send_ok      (data_send_ok),
        .eof_send_ok       (eof_send_ok),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .action            (action),
        .requested_event   (requested_event),
        .eof_condition     (eof_condition),
        .last              (last)
    );

    fdsc_action_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .transport_ready   (transport_ready),
        .file_data_present (file_data_present),
        .file_fully_sent   (file_fully_sent),
        .metadata_send_ok  (metadata_send_ok),
        .data_send_ok      (data_send_ok),
        .eof_send_ok       (eof_send_ok),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .action            (action),
        .requested_event   (requested_event),
        .eof_condition     (eof_condition),
        .last              (last),
        .fails             (fails),
        .backlog           (backlog)
    );

    // receiver stalls at random, except in the calm stretch
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic coin();
        return 1'($urandom);
    endfunction

    // Present one event at a falling edge and hold it until accepted. Valid
    // stays high on return so a back-to-back item never toggles it.
    task automatic send_event(input logic [3:0] ev, input logic tr, input logic fdp,
                              input logic ffs, input logic mok, input logic dok,
                              input logic eok);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        cmd               <= ev;
        transport_ready   <= tr;
        file_data_present <= fdp;
        file_fully_sent   <= ffs;
        metadata_send_ok  <= mok;
        data_send_ok      <= dok;
        eof_send_ok       <= eok;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One file-phase event that keeps the transaction alive. Send data only
    // goes out with a payload that cannot end it: either the transport is
    // not ready, or there is more data and the data send succeeds.
    task automatic random_file_event();
        int         pick;
        logic [3:0] ev;
        logic       tr;
        logic       ffs;
        logic       dok;
        pick = $urandom_range(0, 99);
        tr   = coin();
        ffs  = coin();
        dok  = coin();
        if (pick < 35)
            ev = fdsc_pkg::EV_SEND_DATA;
        else if (pick < 45)
            ev = fdsc_pkg::EV_SUSP_NOTE;
        else if (pick < 55)
            ev = fdsc_pkg::EV_RESUME;
        else if (pick < 63)
            ev = fdsc_pkg::EV_FREEZE;
        else if (pick < 71)
            ev = fdsc_pkg::EV_THAW;
        else if (pick < 76)
            ev = fdsc_pkg::EV_ENTER;
        else if (pick < 80)
            ev = fdsc_pkg::EV_SUSP_REQ;
        else if (pick < 84)
            ev = fdsc_pkg::EV_REPORT;
        else if (pick < 88)
            ev = cancel_ok ? fdsc_pkg::EV_CANCEL_REQ : fdsc_pkg::EV_REPORT;
        else if (pick < 91)
            ev = fdsc_pkg::EV_PUT;
        else
            ev = 4'($urandom_range(EV_RSVD_LO, EV_RSVD_HI));
        if (ev == fdsc_pkg::EV_SEND_DATA && tr && (ffs || !dok))
        begin
            if (coin())
                tr = 1'b0;
            else
            begin
                ffs = 1'b0;
                dok = 1'b1;
            end
        end
        send_event(ev, tr, coin(), ffs, coin(), dok, coin());
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        cmd               = fdsc_pkg::EV_ENTER;
        transport_ready   = 1'b0;
        file_data_present = 1'b0;
        file_fully_sent   = 1'b0;
        metadata_send_ok  = 1'b0;
        data_send_ok      = 1'b0;
        eof_send_ok       = 1'b0;
        out_ready         = 1'b0;
        calm              = 1'b0;
        // about a third of the runs never cancel, so the eof carries no error
        cancel_ok         = ($urandom_range(0, 2) != 0);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- metadata phase ----
        // enter only clears flags; it must produce nothing
        send_event(fdsc_pkg::EV_ENTER, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // anything but enter or put is unsupported here
        send_event(fdsc_pkg::EV_SEND_DATA,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_ABANDON,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(fdsc_pkg::EV_CANCEL_NOTE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_event(fdsc_pkg::EV_SUSP_NOTE,   1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        send_event(fdsc_pkg::EV_SUSP_REQ,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_CANCEL_REQ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(fdsc_pkg::EV_THAW,        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_RSVD_HI,               1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_ENTER,       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // put with file data and a good metadata send opens the file phase
        send_event(fdsc_pkg::EV_PUT,         1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);

        // ---- file phase, directed ----
        send_event(fdsc_pkg::EV_ENTER,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // transport not ready: blocked even with everything sent
        send_event(fdsc_pkg::EV_SEND_DATA, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_event(fdsc_pkg::EV_SEND_DATA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        // second suspend notice is silent
        send_event(fdsc_pkg::EV_SUSP_NOTE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_SUSP_NOTE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // blocked by suspend although the payload would end the transaction
        send_event(fdsc_pkg::EV_SEND_DATA, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        // resume twice: the second only requests send data
        send_event(fdsc_pkg::EV_RESUME,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_RESUME,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(fdsc_pkg::EV_FREEZE,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // blocked by freeze with a data send that would fail
        send_event(fdsc_pkg::EV_SEND_DATA, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        send_event(fdsc_pkg::EV_THAW,      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(fdsc_pkg::EV_THAW,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(fdsc_pkg::EV_REPORT,    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_event(fdsc_pkg::EV_SUSP_REQ,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        // put and reserved codes are unsupported in the file phase
        send_event(fdsc_pkg::EV_PUT,       1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_RSVD_LO,             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        if (cancel_ok)
            send_event(fdsc_pkg::EV_CANCEL_REQ, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);

        // ---- file phase, random ----
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST && i <= CALM_LAST);
            random_file_event();
        end
        calm = 1'b0;

        // ---- close the transaction ----
        // thaw and resume clear both flags so the closing event is not blocked
        send_event(fdsc_pkg::EV_THAW,   coin(), coin(), coin(), coin(), coin(), coin());
        send_event(fdsc_pkg::EV_RESUME, coin(), coin(), coin(), coin(), coin(), coin());
        case ($urandom_range(0, 3))
            0: send_event(fdsc_pkg::EV_SEND_DATA, 1'b1, coin(), 1'b1, coin(), coin(),
                          coin());
            1: send_event(fdsc_pkg::EV_SEND_DATA, 1'b1, coin(), 1'b0, coin(), 1'b0,
                          coin());
            2: send_event(fdsc_pkg::EV_ABANDON, coin(), coin(), coin(), coin(), coin(),
                          coin());
            default: send_event(fdsc_pkg::EV_CANCEL_NOTE, coin(), coin(), coin(), coin(),
                                coin(), coin());
        endcase

        // completed phase ignores every event
        repeat (TAIL_ITEMS)
            send_event(4'($urandom_range(0, 15)), coin(), coin(), coin(), coin(), coin(),
                       coin());
        in_valid <= 1'b0;

        // let every predicted action arrive, then watch for strays
        while (backlog != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial
    begin
        #TIMEOUT;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
